@@ rtl/gru_pkg.sv @@
// Shared types and constants for the Givens rotation unit.
// No dependencies; imported by gru_req_if and the top-level module.
package gru_pkg;

	typedef enum logic {
		OP_GEN   = 1'b0,
		OP_APPLY = 1'b1
	} op_t;

endpackage

@@ rtl/gru_req_if.sv @@
// Request channel: op code and a pair of Q1.F operands.
// Depends on gru_pkg for the op code type.
interface gru_req_if #(parameter int W = 16);
	import gru_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic signed [W-1:0] first_in;
	logic signed [W-1:0] second_in;

	modport source (output valid, output op, output first_in, output second_in, input ready);
	modport sink   (input valid, input op, input first_in, input second_in, output ready);
endinterface

@@ rtl/gru_rsp_if.sv @@
// Response channel: a pair of Q2.F results.
// No dependencies.
interface gru_rsp_if #(parameter int W = 16);
	logic              valid;
	logic              ready;
	logic signed [W:0] first_out;
	logic signed [W:0] second_out;

	modport source (output valid, output first_out, output second_out, input ready);
	modport sink   (input valid, input first_out, input second_out, output ready);
endinterface

@@ rtl/gru_mac.sv @@
// Bit-serial dual multiply-accumulate: p = c*u + s*v, q = c*v - s*u.
// Consumes one bit of u and v per cycle, MSB first; no package dependency.
module gru_mac #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [W:0]     c,
	input  logic signed [W:0]     s,
	input  logic signed [W:0]     u,
	input  logic signed [W:0]     v,
	output logic                  done,
	output logic signed [2*W+2:0] p,
	output logic signed [2*W+2:0] q
);
	localparam int AW = 2 * W + 3;
	localparam int CW = $clog2(W + 2);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [W:0]    c_q, s_q;
	logic [W:0]           u_q, v_q;
	logic signed [AW-1:0] p_q, q_q;
	logic signed [AW-1:0] tc, ts, tcv, tsu, p_d, q_d;

	always_comb begin
		tc  = u_q[W] ? AW'(c_q) : '0;
		ts  = v_q[W] ? AW'(s_q) : '0;
		tcv = v_q[W] ? AW'(c_q) : '0;
		tsu = u_q[W] ? AW'(s_q) : '0;
		if (cnt_q == '0) begin
			p_d = -(tc + ts);
			q_d = -(tcv - tsu);
		end else begin
			p_d = (p_q <<< 1) + tc + ts;
			q_d = (q_q <<< 1) + tcv - tsu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q <= c;
			s_q <= s;
			u_q <= u;
			v_q <= v;
			p_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			u_q <= {u_q[W-1:0], 1'b0};
			v_q <= {v_q[W-1:0], 1'b0};
			p_q <= p_d;
			q_q <= q_d;
		end
	end

	assign done = done_q;
	assign p    = p_q;
	assign q    = q_q;
endmodule

@@ rtl/gru_ratio.sv @@
// Serial ratio unit: round(sqrt(num * 4^W / den) / 2) via restoring division
// then digit-by-digit square root, one bit per cycle; no package dependency.
module gru_ratio #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*W-1:0] num,
	input  logic [2*W-1:0] den,
	output logic           done,
	output logic [W-1:0]   mag
);
	localparam int DW = 2 * W + 1;
	localparam int CW = $clog2(2 * W + 2);
	localparam int SW = W + 6;

	typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

	rstate_t         state_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic [2*W-1:0]  den_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [DW:0]     rad_q;
	logic [W:0]      root_q;
	logic [SW-1:0]   srem_q;
	logic [W-1:0]    mag_q;
	logic [DW:0]     dx;
	logic            dge;
	logic [DW-1:0]   rem_d;
	logic [DW-1:0]   quo_d;
	logic [SW-1:0]   sx, trial;
	logic            sge;
	logic [W:0]      root_d;
	logic [W+1:0]    rnd;

	always_comb begin
		dx    = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		dge   = dx >= (DW + 1)'(den_q);
		rem_d = dge ? DW'(dx - (DW + 1)'(den_q)) : DW'(dx);
		quo_d = {quo_q[DW-2:0], dge};
		sx    = {srem_q[SW-3:0], rad_q[DW:DW-1]};
		trial = SW'({root_q, 2'b01});
		sge   = sx >= trial;
		root_d = {root_q[W-1:0], sge};
		rnd   = (W + 2)'(root_d) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_DIV;
						cnt_q   <= '0;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= R_SQRT;
						cnt_q   <= '0;
					end
				end
				R_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W)) begin
						state_q <= R_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					rem_q <= DW'(num);
					den_q <= den;
					quo_q <= '0;
				end
			end
			R_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				if (cnt_q == CW'(DW - 1)) begin
					rad_q  <= {1'b0, quo_d};
					root_q <= '0;
					srem_q <= '0;
				end
			end
			R_SQRT: begin
				rad_q  <= {rad_q[DW-2:0], 2'b00};
				srem_q <= sge ? sx - trial : sx;
				root_q <= root_d;
				if (cnt_q == CW'(W)) begin
					mag_q <= rnd[W:1];
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign mag  = mag_q;
endmodule

@@ rtl/givens_rotation_unit.sv @@
// Givens rotation unit, top level; uses gru_pkg, gru_req_if, gru_rsp_if,
// gru_mac and gru_ratio. One item at a time; the next beat is taken once the result issues.
// Apply: one bit-serial MAC pass (W+1 steps). Generate on a zero pair skips all passes.
// Generate: three MAC passes (sum of squares, then a square per operand), each square
// followed by a serial division (2W+1 steps) and square root (W+1 steps).
// Reset clears control and sets the stored rotation to identity.
module givens_rotation_unit #(
	parameter int DATA_WIDTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	gru_req_if.sink   req,
	gru_rsp_if.source rsp
);
	import gru_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int AW = 2 * W + 3;

	typedef enum logic [2:0] {S_IDLE, S_SUM, S_SQ, S_RATIO, S_APPLY, S_DONE} state_t;

	state_t               state_q;
	logic                 mac_start_q;
	logic                 rat_start_q;
	logic                 comp_q;
	logic                 rsp_valid_q;
	op_t                  op_q;
	logic signed [W-1:0]  a_q, b_q;
	logic signed [W-1:0]  rot_cos_q, rot_sin_q;
	logic [2*W-1:0]       sum_q, num_q;
	logic [W-1:0]         cm_q, sm_q;
	logic signed [AW-1:0] p_q, q_q;
	logic signed [W:0]    first_q, second_q;

	logic [W-1:0]         ma, mb, msel;
	logic signed [W:0]    mc, ms, mu, mv;
	logic                 mac_done, rat_done;
	logic signed [AW-1:0] mac_p, mac_q;
	logic [W-1:0]         rat_mag;
	logic                 rneg, neg1, neg2;
	logic [W-1:0]         cs, ss;
	logic signed [W:0]    gen1, gen2;
	logic signed [W-1:0]  st_cos, st_sin;

	function automatic logic signed [W:0] round_q(input logic signed [AW-1:0] x);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = x[AW-1] ? AW'(-x) : AW'(x);
		r = (m + (AW'(1) << (W - 2))) >> (W - 1);
		return x[AW-1] ? -(W + 1)'(r) : (W + 1)'(r);
	endfunction

	always_comb begin
		ma   = a_q[W-1] ? W'(-a_q) : W'(a_q);
		mb   = b_q[W-1] ? W'(-b_q) : W'(b_q);
		msel = comp_q ? mb : ma;
		case (state_q)
			S_SUM: begin
				mc = {1'b0, ma};
				ms = {1'b0, mb};
				mu = {1'b0, ma};
				mv = {1'b0, mb};
			end
			S_SQ: begin
				mc = {1'b0, msel};
				ms = '0;
				mu = {1'b0, msel};
				mv = '0;
			end
			default: begin
				mc = {rot_cos_q[W-1], rot_cos_q};
				ms = {rot_sin_q[W-1], rot_sin_q};
				mu = {a_q[W-1], a_q};
				mv = {b_q[W-1], b_q};
			end
		endcase
		rneg   = (ma >= mb) ? a_q[W-1] : b_q[W-1];
		neg1   = a_q[W-1] != rneg;
		neg2   = b_q[W-1] != rneg;
		gen1   = neg1 ? -{1'b0, cm_q} : {1'b0, cm_q};
		gen2   = neg2 ? -{1'b0, sm_q} : {1'b0, sm_q};
		cs     = cm_q[W-1] ? {1'b0, {(W - 1){1'b1}}} : cm_q;
		ss     = sm_q[W-1] ? {1'b0, {(W - 1){1'b1}}} : sm_q;
		st_cos = neg1 ? -$signed(cs) : $signed(cs);
		st_sin = neg2 ? -$signed(ss) : $signed(ss);
	end

	gru_mac #(.W(W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start_q),
		.c      (mc),
		.s      (ms),
		.u      (mu),
		.v      (mv),
		.done   (mac_done),
		.p      (mac_p),
		.q      (mac_q)
	);

	gru_ratio #(.W(W)) u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rat_start_q),
		.num    (num_q),
		.den    (sum_q),
		.done   (rat_done),
		.mag    (rat_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mac_start_q <= 1'b0;
			rat_start_q <= 1'b0;
			comp_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rot_cos_q   <= {1'b0, {(W - 1){1'b1}}};
			rot_sin_q   <= '0;
		end else begin
			mac_start_q <= 1'b0;
			rat_start_q <= 1'b0;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						comp_q <= 1'b0;
						if (req.op == OP_APPLY) begin
							state_q     <= S_APPLY;
							mac_start_q <= 1'b1;
						end else if (req.first_in == '0 && req.second_in == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q     <= S_SUM;
							mac_start_q <= 1'b1;
						end
					end
				end
				S_SUM: begin
					if (mac_done) begin
						state_q     <= S_SQ;
						mac_start_q <= 1'b1;
					end
				end
				S_SQ: begin
					if (mac_done) begin
						state_q     <= S_RATIO;
						rat_start_q <= 1'b1;
					end
				end
				S_RATIO: begin
					if (rat_done) begin
						if (comp_q) begin
							state_q <= S_DONE;
						end else begin
							comp_q      <= 1'b1;
							state_q     <= S_SQ;
							mac_start_q <= 1'b1;
						end
					end
				end
				S_APPLY: begin
					if (mac_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (op_q == OP_GEN) begin
							rot_cos_q <= st_cos;
							rot_sin_q <= st_sin;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q <= req.op;
			a_q  <= req.first_in;
			b_q  <= req.second_in;
			cm_q <= W'(1) << (W - 1);
			sm_q <= '0;
		end
		if (state_q == S_SUM && mac_done) begin
			sum_q <= mac_p[2*W-1:0];
		end
		if (state_q == S_SQ && mac_done) begin
			num_q <= mac_p[2*W-1:0];
		end
		if (state_q == S_RATIO && rat_done) begin
			if (comp_q) begin
				sm_q <= rat_mag;
			end else begin
				cm_q <= rat_mag;
			end
		end
		if (state_q == S_APPLY && mac_done) begin
			p_q <= mac_p;
			q_q <= mac_q;
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			if (op_q == OP_GEN) begin
				first_q  <= gen1;
				second_q <= gen2;
			end else begin
				first_q  <= round_q(p_q);
				second_q <= round_q(q_q);
			end
		end
	end

	assign req.ready      = state_q == S_IDLE;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.first_out  = first_q;
	assign rsp.second_out = second_q;
endmodule

@@ rtl/gru_checker.sv @@
// Port-level checks for the Givens rotation unit, bound to the top level.
// No package dependency.
module gru_checker #(
	parameter int W = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic signed [W:0] rsp_first_out,
	input logic signed [W:0] rsp_second_out
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_out)
			&& $stable(rsp_second_out))
		else $error("response beat dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared one cycle after accept");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result issued while the unit is still busy");
endmodule

bind givens_rotation_unit gru_checker #(.W(DATA_WIDTH)) u_gru_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_first_out  (rsp.first_out),
	.rsp_second_out (rsp.second_out)
);
